FILE: src/pcth_pkg.sv
// Shared types, constants and CRC helpers for the path CRC triple hasher.
`default_nettype none

package pcth_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [7:0]  SEP_BYTE  = 8'h5C;
    localparam logic [7:0]  SLASH     = 8'h2F;
    localparam logic [7:0]  DOT_BYTE  = 8'h2E;
    localparam logic [7:0]  UPPER_LO  = 8'h41;
    localparam logic [7:0]  UPPER_HI  = 8'h5A;
    localparam logic [7:0]  CASE_BIAS = 8'h20;
    localparam logic [2:0]  EXT_MAX   = 3'd4;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       is_last;
    } path_item_t;

    typedef struct packed {
        logic [31:0] folder_hash;
        logic [31:0] file_hash;
        logic [31:0] ext_code;
    } path_result_t;

    // Reflected CRC-32 over one byte, unrolled bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] normalize(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == SLASH)
        begin
            r = SEP_BYTE;
        end
        else if (b >= UPPER_LO && b <= UPPER_HI)
        begin
            r = b + CASE_BIAS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/pcth_seg_tracker.sv
// Per-path state: whole-path and segment CRCs, snapshots and extension capture.
`default_nettype none

module pcth_seg_tracker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire pcth_pkg::path_item_t  item,
    output pcth_pkg::path_result_t     result
);

    logic [31:0] path_crc_reg,  path_crc_next;
    logic [31:0] folder_reg,    folder_next;
    logic [31:0] segment_reg,   segment_next;
    logic [31:0] stem_reg,      stem_next;
    logic        seen_dot_reg,  seen_dot_next;
    logic [31:0] ext_word_reg,  ext_word_next;
    logic [2:0]  ext_bytes_reg, ext_bytes_next;

    logic [7:0]  b;
    logic [31:0] seg_crc_upd;

    always_comb
    begin
        b              = pcth_pkg::normalize(item.path_byte);
        seg_crc_upd    = pcth_pkg::crc_byte(segment_reg, b);
        path_crc_next  = pcth_pkg::crc_byte(path_crc_reg, b);
        folder_next    = folder_reg;
        segment_next   = seg_crc_upd;
        stem_next      = stem_reg;
        seen_dot_next  = seen_dot_reg;
        ext_word_next  = ext_word_reg;
        ext_bytes_next = ext_bytes_reg;

        if (b == pcth_pkg::SEP_BYTE)
        begin
            folder_next    = path_crc_reg;
            segment_next   = '0;
            seen_dot_next  = 1'b0;
            ext_word_next  = '0;
            ext_bytes_next = '0;
        end
        else if (b == pcth_pkg::DOT_BYTE)
        begin
            stem_next      = segment_reg;
            seen_dot_next  = 1'b1;
            ext_word_next  = '0;
            ext_bytes_next = '0;
        end
        else if (seen_dot_reg && ext_bytes_reg < pcth_pkg::EXT_MAX)
        begin
            unique case (ext_bytes_reg[1:0])
                2'd0:    ext_word_next[7:0]   = b;
                2'd1:    ext_word_next[15:8]  = b;
                2'd2:    ext_word_next[23:16] = b;
                default: ext_word_next[31:24] = b;
            endcase
            ext_bytes_next = ext_bytes_reg + 3'd1;
        end

        result.folder_hash = folder_next;
        result.file_hash   = seen_dot_next ? stem_next : segment_next;
        result.ext_code    = ext_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_crc_reg  <= '0;
            folder_reg    <= '0;
            segment_reg   <= '0;
            stem_reg      <= '0;
            seen_dot_reg  <= 1'b0;
            ext_word_reg  <= '0;
            ext_bytes_reg <= '0;
        end
        else if (step)
        begin
            if (item.is_last)
            begin
                // path done: start clean for the next one
                path_crc_reg  <= '0;
                folder_reg    <= '0;
                segment_reg   <= '0;
                stem_reg      <= '0;
                seen_dot_reg  <= 1'b0;
                ext_word_reg  <= '0;
                ext_bytes_reg <= '0;
            end
            else
            begin
                path_crc_reg  <= path_crc_next;
                folder_reg    <= folder_next;
                segment_reg   <= segment_next;
                stem_reg      <= stem_next;
                seen_dot_reg  <= seen_dot_next;
                ext_word_reg  <= ext_word_next;
                ext_bytes_reg <= ext_bytes_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ext_bytes_reg <= pcth_pkg::EXT_MAX)
        else $error("extension byte count past limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_dot_reg |-> (ext_bytes_reg == 3'd0 && ext_word_reg == 32'd0))
        else $error("extension captured without a dot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.is_last) |=> (path_crc_reg == 32'd0 && !seen_dot_reg))
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

FILE: src/path_crc_triple_hasher_unit.sv
// Path CRC triple hasher: top level with input stage and result register.
//
// Usage: the sender presents one path byte per transaction on item/item_valid,
// with item.is_last set on the final byte of a path. Slashes count as
// backslashes and A..Z fold to lower case. On the last byte one result
// transaction appears on result/result_valid carrying the folder CRC, the
// file stem CRC and up to four extension bytes packed little-endian.
// Throughput: one byte per cycle while no last byte is held back; the input
// stage and the per-path state advance together through one byte-wide CRC
// update per hash. An accepted byte waits in the input stage; from there
// it is processed, and a last byte's result goes into the result register.
// Stall: a waiting result holds in the result register while non-last bytes
// keep flowing; only a last byte waits in the input stage, and item_stall
// rises once that stage is blocked.
// Reset: rst_n clears the stage valid, the result valid and all path state;
// the block accepts bytes as soon as reset is released.
`default_nettype none

module path_crc_triple_hasher_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pcth_pkg::path_item_t    item,
    input  wire logic                    item_valid,
    output logic                         item_stall,
    output pcth_pkg::path_result_t       result,
    output logic                         result_valid,
    input  wire logic                    result_stall
);

    pcth_pkg::path_item_t   stage_reg;
    logic                   stage_valid_reg;
    pcth_pkg::path_result_t result_reg;
    logic                   result_valid_reg;
    pcth_pkg::path_result_t calc;
    logic                   advance;
    logic                   accept;

    assign advance = stage_valid_reg
                     && (!stage_reg.is_last || !result_valid_reg || !result_stall);
    assign item_stall   = stage_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    pcth_seg_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_reg),
        .result (calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance && stage_reg.is_last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= item;
        end
        if (advance && stage_reg.is_last)
        begin
            result_reg <= calc;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && stage_reg.is_last && result_valid_reg))
        else $error("input stalled without a blocked last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stage_valid_reg && stage_reg.is_last))
        else $error("result raised without a last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_reg.is_last) |-> !item_stall)
        else $error("non-last byte held in stage");

endmodule

`default_nettype wire
